### design/rtq_pkg.sv
package rtq_pkg;

    localparam int REF_DEPTH  = 64;
    localparam int REF_AW     = $clog2(REF_DEPTH);
    localparam int DESC_DEPTH = 64;
    localparam int DESC_AW    = $clog2(DESC_DEPTH);
    localparam int RING_SIZE  = 256;
    localparam int RING_AW    = $clog2(RING_SIZE);

    localparam logic [7:0] RETRY_LIMIT_RST = 8'd6;

    typedef enum logic [1:0]
    {
        CMD_ENQ_REF  = 2'd0,
        CMD_ENQ_COPY = 2'd1,
        CMD_CONFIRM  = 2'd2,
        CMD_RETRY    = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        LINK_READY      = 2'd0,
        LINK_WAIT_CONF  = 2'd1,
        LINK_WAIT_RETRY = 2'd2
    } link_t;

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_ISSUE = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    typedef struct packed
    {
        logic [15:0] handle;
        logic [7:0]  length;
        logic [15:0] dest;
    } ref_entry_t;

    typedef struct packed
    {
        logic [RING_AW-1:0] offset;
        logic [7:0]         length;
        logic [15:0]        dest;
    } desc_entry_t;

    // write and read requests toward the entry store
    typedef struct packed
    {
        logic              ref_we;
        logic [REF_AW-1:0] ref_waddr;
        ref_entry_t        ref_wdata;
        logic [REF_AW-1:0] ref_raddr;
        logic               desc_we;
        logic [DESC_AW-1:0] desc_waddr;
        desc_entry_t        desc_wdata;
        logic [DESC_AW-1:0] desc_raddr;
    } mem_req_t;

endpackage

### design/radio_tx_queue_with_retry.sv
// a request that may issue the next message (an accepted enqueue, or a confirm
// that ends the pending one) passes through the memory read, issue and output load states
// before its result is valid; any other request goes straight to the output load
// the block takes no new request until the result sits in the output register, so it
// stays busy for longer while the result side stalls
// reset: pointers, link, fail count, pending send cleared, retry limit 6; memories left as is
module radio_tx_queue_with_retry
(
    input  logic        clk,
    input  logic        rst_n,

    // retry limit register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // handle[15:0], msg_length[23:16], dest_addr[39:24],
                                    // success[40], zero fill
    input  logic [1:0]  s_tuser,    // cmd[1:0]

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // accepted[0], send_valid[1], send_handle[17:2],
                                    // send_offset[25:18], send_length[33:26],
                                    // send_dest[49:34], retransmit[50], dropped[51], zero fill
    output logic        m_tuser     // send_is_copy
);

    // message currently handed to the radio
    typedef struct packed
    {
        logic                        is_copy;
        logic [15:0]                 handle;
        logic [rtq_pkg::RING_AW-1:0] offset;
        logic [7:0]                  length;
        logic [15:0]                 dest;
    } pend_t;

    rtq_pkg::state_t state_reg, state_next;
    rtq_pkg::link_t  link_reg, link_next;

    logic [rtq_pkg::REF_AW-1:0]  ref_head_reg, ref_head_next;
    logic [rtq_pkg::REF_AW-1:0]  ref_tail_reg, ref_tail_next;
    logic [rtq_pkg::DESC_AW-1:0] desc_head_reg, desc_head_next;
    logic [rtq_pkg::DESC_AW-1:0] desc_tail_reg, desc_tail_next;
    logic [rtq_pkg::RING_AW-1:0] byte_head_reg, byte_head_next;
    logic [rtq_pkg::RING_AW-1:0] byte_tail_reg, byte_tail_next;
    logic [7:0]                  fail_reg, fail_next;
    logic [7:0]                  retry_limit_reg;
    pend_t                       pend_reg, pend_next;

    // result flags gathered while a request is worked on
    logic res_acc_reg, res_acc_next;
    logic res_sent_reg, res_sent_next;
    logic res_retx_reg, res_retx_next;
    logic res_drop_reg, res_drop_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    rtq_pkg::mem_req_t     mem_req;
    rtq_pkg::ref_entry_t   ref_rdata;
    rtq_pkg::desc_entry_t  desc_rdata;

    // request fields
    rtq_pkg::cmd_t cmd;
    logic [15:0]   in_handle;
    logic [7:0]    in_len;
    logic [15:0]   in_dest;
    logic          in_success;

    logic s_fire;
    logic out_free;

    logic [rtq_pkg::REF_AW-1:0]  ref_used;
    logic [rtq_pkg::DESC_AW-1:0] desc_used;
    logic [rtq_pkg::RING_AW-1:0] byte_used;
    logic [rtq_pkg::RING_AW-1:0] byte_free;
    logic ref_room, copy_room;
    logic ref_empty, desc_empty;
    logic [7:0] fail_inc;
    logic       limit_hit;
    logic       need_issue;

    assign cmd        = rtq_pkg::cmd_t'(s_tuser);
    assign in_handle  = s_tdata[15:0];
    assign in_len     = s_tdata[23:16];
    assign in_dest    = s_tdata[39:24];
    assign in_success = s_tdata[40];

    assign s_tready = (state_reg == rtq_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // occupancy; one slot of each queue and one ring byte stay free
    assign ref_used  = ref_tail_reg - ref_head_reg;
    assign desc_used = desc_tail_reg - desc_head_reg;
    assign byte_used = byte_tail_reg - byte_head_reg;
    assign byte_free = rtq_pkg::RING_AW'(rtq_pkg::RING_SIZE - 1) - byte_used;
    assign ref_room  = (ref_used != rtq_pkg::REF_AW'(rtq_pkg::REF_DEPTH - 1));
    assign copy_room = (desc_used != rtq_pkg::DESC_AW'(rtq_pkg::DESC_DEPTH - 1))
                       && ({{(16 - rtq_pkg::RING_AW){1'b0}}, byte_free} >= {8'd0, in_len});
    assign ref_empty  = (ref_used == '0);
    assign desc_empty = (desc_used == '0);

    // failure counter wraps at 8 bits, so a limit of zero means 256 failures
    assign fail_inc  = fail_reg + 8'd1;
    assign limit_hit = (fail_inc == retry_limit_reg);

    // requests after which the next queued message may go out
    always_comb
    begin
        need_issue = 1'b0;
        case (cmd)
            rtq_pkg::CMD_ENQ_REF:  need_issue = ref_room;
            rtq_pkg::CMD_ENQ_COPY: need_issue = copy_room;
            rtq_pkg::CMD_CONFIRM:  need_issue = (link_reg == rtq_pkg::LINK_WAIT_CONF)
                                                && (in_success || limit_hit);
            rtq_pkg::CMD_RETRY:    need_issue = 1'b0;
            default:               need_issue = 1'b0;
        endcase
    end

    rtq_entry_store u_store
    (
        .clk        (clk),
        .req        (mem_req),
        .ref_rdata  (ref_rdata),
        .desc_rdata (desc_rdata)
    );

    // sequencer: accept, then, for a request that may issue, read the queue heads and issue, then hand the result over
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtq_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = need_issue ? rtq_pkg::ST_READ : rtq_pkg::ST_OUT;
                end
            end
            rtq_pkg::ST_READ:  state_next = rtq_pkg::ST_ISSUE;
            rtq_pkg::ST_ISSUE: state_next = rtq_pkg::ST_OUT;
            rtq_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = rtq_pkg::ST_IDLE;
                end
            end
            default:           state_next = rtq_pkg::ST_IDLE;
        endcase
    end

    // datapath: queue writes, link handling, issue from the head read data
    always_comb
    begin
        ref_head_next  = ref_head_reg;
        ref_tail_next  = ref_tail_reg;
        desc_head_next = desc_head_reg;
        desc_tail_next = desc_tail_reg;
        byte_head_next = byte_head_reg;
        byte_tail_next = byte_tail_reg;
        link_next      = link_reg;
        fail_next      = fail_reg;
        pend_next      = pend_reg;
        res_acc_next   = res_acc_reg;
        res_sent_next  = res_sent_reg;
        res_retx_next  = res_retx_reg;
        res_drop_next  = res_drop_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        // heads are read every cycle; writes only at a transfer
        mem_req                   = '0;
        mem_req.ref_raddr         = ref_head_reg;
        mem_req.desc_raddr        = desc_head_reg;
        mem_req.ref_waddr         = ref_tail_reg;
        mem_req.ref_wdata.handle  = in_handle;
        mem_req.ref_wdata.length  = in_len;
        mem_req.ref_wdata.dest    = in_dest;
        mem_req.desc_waddr        = desc_tail_reg;
        mem_req.desc_wdata.offset = byte_tail_reg;
        mem_req.desc_wdata.length = in_len;
        mem_req.desc_wdata.dest   = in_dest;

        case (state_reg)
            rtq_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    res_acc_next  = 1'b0;
                    res_sent_next = 1'b0;
                    res_retx_next = 1'b0;
                    res_drop_next = 1'b0;
                    case (cmd)
                        rtq_pkg::CMD_ENQ_REF:
                        begin
                            if (ref_room)
                            begin
                                mem_req.ref_we = 1'b1;
                                ref_tail_next  = ref_tail_reg + rtq_pkg::REF_AW'(1);
                                res_acc_next   = 1'b1;
                            end
                        end
                        rtq_pkg::CMD_ENQ_COPY:
                        begin
                            if (copy_room)
                            begin
                                mem_req.desc_we = 1'b1;
                                desc_tail_next  = desc_tail_reg + rtq_pkg::DESC_AW'(1);
                                byte_tail_next  = byte_tail_reg + in_len[rtq_pkg::RING_AW-1:0];
                                res_acc_next    = 1'b1;
                            end
                        end
                        rtq_pkg::CMD_CONFIRM:
                        begin
                            // a confirm nobody waits for is ignored
                            if (link_reg == rtq_pkg::LINK_WAIT_CONF)
                            begin
                                if (in_success)
                                begin
                                    fail_next = 8'd0;
                                    link_next = rtq_pkg::LINK_READY;
                                end
                                else if (limit_hit)
                                begin
                                    fail_next     = 8'd0;
                                    res_drop_next = 1'b1;
                                    link_next     = rtq_pkg::LINK_READY;
                                end
                                else
                                begin
                                    fail_next = fail_inc;
                                    link_next = rtq_pkg::LINK_WAIT_RETRY;
                                end
                            end
                        end
                        rtq_pkg::CMD_RETRY:
                        begin
                            // resend the pending message as it stands
                            if (link_reg == rtq_pkg::LINK_WAIT_RETRY)
                            begin
                                link_next     = rtq_pkg::LINK_WAIT_CONF;
                                res_sent_next = 1'b1;
                                res_retx_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rtq_pkg::ST_ISSUE:
            begin
                // reference messages go before copies
                if (link_reg == rtq_pkg::LINK_READY)
                begin
                    if (!ref_empty)
                    begin
                        pend_next.is_copy = 1'b0;
                        pend_next.handle  = ref_rdata.handle;
                        pend_next.offset  = '0;
                        pend_next.length  = ref_rdata.length;
                        pend_next.dest    = ref_rdata.dest;
                        ref_head_next     = ref_head_reg + rtq_pkg::REF_AW'(1);
                        res_sent_next     = 1'b1;
                        link_next         = rtq_pkg::LINK_WAIT_CONF;
                    end
                    else if (!desc_empty)
                    begin
                        pend_next.is_copy = 1'b1;
                        pend_next.handle  = 16'd0;
                        pend_next.offset  = desc_rdata.offset;
                        pend_next.length  = desc_rdata.length;
                        pend_next.dest    = desc_rdata.dest;
                        desc_head_next    = desc_head_reg + rtq_pkg::DESC_AW'(1);
                        // ring bytes are released at the first issue
                        byte_head_next    = byte_head_reg
                                            + desc_rdata.length[rtq_pkg::RING_AW-1:0];
                        res_sent_next     = 1'b1;
                        link_next         = rtq_pkg::LINK_WAIT_CONF;
                    end
                end
            end
            rtq_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_sent_reg && pend_reg.is_copy;
                    if (res_sent_reg)
                    begin
                        m_tdata_next = {4'd0, res_drop_reg, res_retx_reg, pend_reg.dest,
                                        pend_reg.length, 8'(pend_reg.offset), pend_reg.handle,
                                        1'b1, res_acc_reg};
                    end
                    else
                    begin
                        m_tdata_next = {4'd0, res_drop_reg, 1'b0, 48'd0, 1'b0, res_acc_reg};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtq_pkg::ST_IDLE;
            link_reg      <= rtq_pkg::LINK_READY;
            ref_head_reg  <= '0;
            ref_tail_reg  <= '0;
            desc_head_reg <= '0;
            desc_tail_reg <= '0;
            byte_head_reg <= '0;
            byte_tail_reg <= '0;
            fail_reg      <= 8'd0;
            pend_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            link_reg      <= link_next;
            ref_head_reg  <= ref_head_next;
            ref_tail_reg  <= ref_tail_next;
            desc_head_reg <= desc_head_next;
            desc_tail_reg <= desc_tail_next;
            byte_head_reg <= byte_head_next;
            byte_tail_reg <= byte_tail_next;
            fail_reg      <= fail_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // retry limit register; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= rtq_pkg::RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            retry_limit_reg <= cfg_wdata;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        res_acc_reg  <= res_acc_next;
        res_sent_reg <= res_sent_next;
        res_retx_reg <= res_retx_next;
        res_drop_reg <= res_drop_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a retransmit is always a send
    a_retx_is_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[50] || m_tdata[1]))
        else $error("retransmit without send");

    // a drop and a retransmit never share one result
    a_drop_not_retx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[51] && m_tdata[50]))
        else $error("drop and retransmit together");

    // the block takes one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("request accepted while busy");

    // an issue from a non-empty queue leaves the link waiting for a confirm
    a_issue_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtq_pkg::ST_ISSUE && link_reg == rtq_pkg::LINK_READY
         && (!ref_empty || !desc_empty))
        |=> (link_reg == rtq_pkg::LINK_WAIT_CONF && res_sent_reg))
        else $error("issue did not arm confirm wait");

endmodule

### design/rtq_entry_store.sv
module rtq_entry_store
(
    input  logic                  clk,
    input  rtq_pkg::mem_req_t     req,
    output rtq_pkg::ref_entry_t   ref_rdata,
    output rtq_pkg::desc_entry_t  desc_rdata
);

    rtq_pkg::ref_entry_t  ref_mem  [rtq_pkg::REF_DEPTH];
    rtq_pkg::desc_entry_t desc_mem [rtq_pkg::DESC_DEPTH];

    rtq_pkg::ref_entry_t  ref_rd_reg;
    rtq_pkg::desc_entry_t desc_rd_reg;

    // reference queue storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.ref_we)
        begin
            ref_mem[req.ref_waddr] <= req.ref_wdata;
        end
        ref_rd_reg <= ref_mem[req.ref_raddr];
    end

    // copy descriptor storage
    always_ff @(posedge clk)
    begin
        if (req.desc_we)
        begin
            desc_mem[req.desc_waddr] <= req.desc_wdata;
        end
        desc_rd_reg <= desc_mem[req.desc_raddr];
    end

    assign ref_rdata  = ref_rd_reg;
    assign desc_rdata = desc_rd_reg;

endmodule

### test/rtq_send_checker.sv
`timescale 1ns / 1ps

module rtq_send_checker
    import rtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          outstanding
);

    typedef struct packed
    {
        logic               is_copy;
        logic [15:0]        handle;
        logic [RING_AW-1:0] offset;
        logic [7:0]         length;
        logic [15:0]        dest;
    } msg_t;

    typedef struct packed
    {
        logic        accepted;
        logic        send_valid;
        logic        is_copy;
        logic [15:0] handle;
        logic [7:0]  offset;
        logic [7:0]  length;
        logic [15:0] dest;
        logic        retransmit;
        logic        dropped;
    } send_result_t;

    msg_t               ref_store [REF_DEPTH];
    msg_t               copy_store [DESC_DEPTH];
    logic [REF_AW-1:0]  ref_rd, ref_wr;
    logic [DESC_AW-1:0] desc_rd, desc_wr;
    logic [RING_AW-1:0] ring_rd, ring_wr;
    link_t              link;
    logic [7:0]         fails;
    logic [7:0]         retry_limit;
    msg_t               on_air;
    send_result_t       sends_due [$];
    int                 err_total = 0;

    // reference entries go ahead of copies; ring bytes free on first issue
    function automatic bit launch_next();
        if (link != LINK_READY)
            return 1'b0;
        if (ref_rd != ref_wr)
        begin
            on_air = ref_store[ref_rd];
            ref_rd = ref_rd + REF_AW'(1);
        end
        else if (desc_rd != desc_wr)
        begin
            on_air  = copy_store[desc_rd];
            desc_rd = desc_rd + DESC_AW'(1);
            ring_rd = ring_rd + on_air.length;
        end
        else
            return 1'b0;
        link = LINK_WAIT_CONF;
        return 1'b1;
    endfunction

    function automatic send_result_t predict_send(cmd_t cmd, logic [15:0] handle,
                                                  logic [7:0] len, logic [15:0] dest,
                                                  logic ok);
        send_result_t       r;
        msg_t               m;
        logic [REF_AW-1:0]  ref_used;
        logic [DESC_AW-1:0] desc_used;
        logic [RING_AW-1:0] ring_used;
        r         = '0;
        m         = '0;
        ref_used  = ref_wr - ref_rd;
        desc_used = desc_wr - desc_rd;
        ring_used = ring_wr - ring_rd;
        case (cmd)
            CMD_ENQ_REF:
            begin
                if (int'(ref_used) < REF_DEPTH - 1)
                begin
                    m.handle          = handle;
                    m.length          = len;
                    m.dest            = dest;
                    ref_store[ref_wr] = m;
                    ref_wr            = ref_wr + REF_AW'(1);
                    r.accepted        = 1'b1;
                    r.send_valid      = launch_next();
                end
            end
            CMD_ENQ_COPY:
            begin
                // one spare slot and one spare ring byte keep full apart from empty
                if (int'(desc_used) < DESC_DEPTH - 1 &&
                    RING_SIZE - 1 - int'(ring_used) >= int'(len))
                begin
                    m.is_copy           = 1'b1;
                    m.offset            = ring_wr;
                    m.length            = len;
                    m.dest              = dest;
                    copy_store[desc_wr] = m;
                    desc_wr             = desc_wr + DESC_AW'(1);
                    ring_wr             = ring_wr + len;
                    r.accepted          = 1'b1;
                    r.send_valid        = launch_next();
                end
            end
            CMD_CONFIRM:
            begin
                if (link == LINK_WAIT_CONF)
                begin
                    if (ok)
                    begin
                        fails        = '0;
                        link         = LINK_READY;
                        r.send_valid = launch_next();
                    end
                    else
                    begin
                        fails = fails + 8'd1;
                        if (fails == retry_limit)
                        begin
                            fails        = '0;
                            r.dropped    = 1'b1;
                            link         = LINK_READY;
                            r.send_valid = launch_next();
                        end
                        else
                            link = LINK_WAIT_RETRY;
                    end
                end
            end
            default:
            begin
                if (link == LINK_WAIT_RETRY)
                begin
                    link         = LINK_WAIT_CONF;
                    r.send_valid = 1'b1;
                    r.retransmit = 1'b1;
                end
            end
        endcase
        if (r.send_valid)
        begin
            r.is_copy = on_air.is_copy;
            r.handle  = on_air.handle;
            r.offset  = on_air.offset;
            r.length  = on_air.length;
            r.dest    = on_air.dest;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_total++;
        end
    endtask

    task automatic check_result();
        send_result_t want;
        if (sends_due.size() == 0)
        begin
            $error("result transfer with no request waiting: m_tdata %h", m_tdata);
            err_total++;
        end
        else
        begin
            want = sends_due.pop_front();
            check_field("accepted", 16'(want.accepted), 16'(m_tdata[0]));
            check_field("send_valid", 16'(want.send_valid), 16'(m_tdata[1]));
            check_field("send_handle", want.handle, m_tdata[17:2]);
            check_field("send_offset", 16'(want.offset), 16'(m_tdata[25:18]));
            check_field("send_length", 16'(want.length), 16'(m_tdata[33:26]));
            check_field("send_dest", want.dest, m_tdata[49:34]);
            check_field("retransmit", 16'(want.retransmit), 16'(m_tdata[50]));
            check_field("dropped", 16'(want.dropped), 16'(m_tdata[51]));
            check_field("send_is_copy", 16'(want.is_copy), 16'(m_tuser));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_rd      = '0;
            ref_wr      = '0;
            desc_rd     = '0;
            desc_wr     = '0;
            ring_rd     = '0;
            ring_wr     = '0;
            link        = LINK_READY;
            fails       = '0;
            on_air      = '0;
            retry_limit = RETRY_LIMIT_RST;
            sends_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                retry_limit = cfg_wdata;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                sends_due.push_back(predict_send(cmd_t'(s_tuser), s_tdata[15:0],
                                                 s_tdata[23:16], s_tdata[39:24],
                                                 s_tdata[40]));
            outstanding <= sends_due.size();
            errors      <= err_total;
        end
    end

endmodule

### test/radio_tx_queue_with_retry_tb.sv
`timescale 1ns / 1ps

module radio_tx_queue_with_retry_tb;
    import rtq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [47:0] s_tdata   = '0;    // handle, msg_length, dest_addr, success, zero fill
    logic [1:0]  s_tuser   = '0;    // cmd
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [55:0] m_tdata;           // accepted, send_valid, send_handle, send_offset,
                                    // send_length, send_dest, retransmit, dropped, zero fill
    wire         m_tuser;           // send_is_copy

    int          errors;
    int          outstanding;
    int          cycles      = 0;
    int          send_idle   = 0;   // percent of cycles the request side holds back
    int          recv_stall  = 0;   // percent of cycles the result side stalls
    int          backlog     = 0;   // messages believed queued or on the air
    int          items_sent  = 0;
    logic [7:0]  retry_limit = RETRY_LIMIT_RST;

    radio_tx_queue_with_retry u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // watches both streams and the register port, predicts every result
    rtq_send_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request transfer; valid stays high straight into the next request
    // unless the sender decides to idle first
    task automatic push_request(cmd_t cmd, logic [15:0] handle, logic [7:0] len,
                                logic [15:0] dest, logic ok);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, ok, dest, len, handle};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // mostly short messages, now and then the empty and the full-size ones
    function automatic logic [7:0] random_length();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(255));
            default: return 8'($urandom_range(1, 60));
        endcase
    endfunction

    task automatic enqueue_random();
        push_request($urandom_range(1) ? CMD_ENQ_COPY : CMD_ENQ_REF,
                     16'($urandom_range(65535)), random_length(),
                     16'($urandom_range(65535)), 1'($urandom_range(1)));
        backlog++;
    endtask

    // walk the message on the air to success, or to a drop at the retry limit;
    // a limit of zero wraps the 8-bit counter, so it takes 256 failures
    task automatic settle_message(bit drop);
        int eff;
        int n;
        eff = (retry_limit == 8'd0) ? 256 : int'(retry_limit);
        n   = drop ? eff - 1 : int'($urandom_range((eff - 1 < 4) ? eff - 1 : 4));
        repeat (n)
        begin
            push_request(CMD_CONFIRM, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                         16'($urandom_range(65535)), 1'b0);
            push_request(CMD_RETRY, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                         16'($urandom_range(65535)), 1'($urandom_range(1)));
        end
        push_request(CMD_CONFIRM, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)), !drop);
    endtask

    task automatic drain_backlog();
        int eff;
        eff = (retry_limit == 8'd0) ? 256 : int'(retry_limit);
        while (backlog > 0)
        begin
            // new work may arrive while the link is busy
            if ($urandom_range(6) == 0)
                enqueue_random();
            settle_message(eff <= 8 && $urandom_range(4) == 0);
            backlog--;
        end
    endtask

    // push one queue past full, then let it empty again
    task automatic fill_queue(bit copies);
        repeat (66)
            push_request(copies ? CMD_ENQ_COPY : CMD_ENQ_REF, 16'($urandom_range(65535)),
                         copies ? 8'($urandom_range(3)) : random_length(),
                         16'($urandom_range(65535)), 1'($urandom_range(1)));
        backlog += 64;
        drain_backlog();
    endtask

    task automatic run_traffic(int budget);
        int stop;
        stop = items_sent + budget;
        while (items_sent < stop)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_request(cmd_t'($urandom_range(3)), 16'($urandom_range(65535)),
                             8'($urandom_range(255)), 16'($urandom_range(65535)),
                             1'($urandom_range(1)));
                // stray requests are mostly ignored, so they are not counted
                items_sent--;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    enqueue_random();
                drain_backlog();
            end
        end
    endtask

    // block is idle once every result is out and the pipeline has emptied
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_retry_limit(logic [7:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        retry_limit = value;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, retry limit still at its reset value of 6
        // confirm and retry tick with nothing on the air are ignored
        push_request(CMD_CONFIRM, 16'h0000, 8'h00, 16'h0000, 1'b1);
        push_request(CMD_RETRY, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        // first reference goes on the air at once, the second waits
        push_request(CMD_ENQ_REF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        push_request(CMD_ENQ_REF, 16'h0000, 8'h01, 16'h0000, 1'b0);
        // full-size copy takes the whole ring but the spare byte
        push_request(CMD_ENQ_COPY, 16'h5555, 8'hFF, 16'hAAAA, 1'b0);
        // one more byte does not fit, a zero-length copy does
        push_request(CMD_ENQ_COPY, 16'hAAAA, 8'h01, 16'h5555, 1'b1);
        push_request(CMD_ENQ_COPY, 16'h1234, 8'h00, 16'h4321, 1'b0);
        // retry tick while a confirm is awaited is ignored
        push_request(CMD_RETRY, 16'h0000, 8'h00, 16'h0000, 1'b0);
        push_request(CMD_CONFIRM, 16'h0000, 8'h00, 16'h0000, 1'b0);
        // confirm while a retry tick is awaited is ignored
        push_request(CMD_CONFIRM, 16'h0000, 8'h00, 16'h0000, 1'b1);
        // resend until the sixth failure drops it and the next reference goes out
        repeat (5)
        begin
            push_request(CMD_RETRY, 16'h0000, 8'h00, 16'h0000, 1'b0);
            push_request(CMD_CONFIRM, 16'h0000, 8'h00, 16'h0000, 1'b0);
        end
        // copies follow, the ring frees on issue and a large copy fits again
        repeat (3)
            push_request(CMD_CONFIRM, 16'h0000, 8'h00, 16'h0000, 1'b1);
        push_request(CMD_ENQ_COPY, 16'hBEEF, 8'd200, 16'h0F0F, 1'b0);
        push_request(CMD_CONFIRM, 16'h0000, 8'h00, 16'h0000, 1'b1);

        // lowest limit, every failure drops; no idling on either side
        set_retry_limit(8'd1);
        run_traffic(60);
        fill_queue(1'b0);

        // highest limit, sender mostly idle
        send_idle = 76;
        set_retry_limit(8'd255);
        run_traffic(100);

        // limit zero wraps the failure counter; receiver mostly stalling
        send_idle  = 0;
        recv_stall = 76;
        set_retry_limit(8'd0);
        push_request(CMD_ENQ_REF, 16'($urandom_range(65535)), random_length(),
                     16'($urandom_range(65535)), 1'b0);
        settle_message(1'b1);
        run_traffic(40);

        // light idling on both sides with a small limit
        send_idle  = 20;
        recv_stall = 20;
        set_retry_limit(8'($urandom_range(2, 8)));
        run_traffic(60);
        fill_queue(1'b1);

        wait_idle();
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
